### hw/rtl/vpa_pkg.sv
// vpa_pkg: shared types and codes for the variable partition allocator
// no dependencies
package vpa_pkg;

   localparam int unsigned FIELD_W = 16;

   typedef logic [2:0]  status_type;
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_BAD_SIZE  = 3'd1;
   localparam status_type ST_NO_SPACE  = 3'd2;
   localparam status_type ST_BAD_ID    = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_FIT_MODE = 2'd0;
   localparam csr_index_type CSR_MEM_TOTAL = 2'd1;
   localparam csr_index_type CSR_SLACK     = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [15:0] MEM_TOTAL_RESET = 16'd1024;
   localparam logic [7:0]  SLACK_RESET     = 8'd10;
   localparam logic [15:0] ID_MAX          = 16'hFFFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_ALLOC_SLOT,
      S_ALLOC_APPLY,
      S_REMOVE_SHIFT,
      S_FREE_FIND,
      S_FREE_POS,
      S_FREE_APPLY,
      S_INSERT_SHIFT,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] alloc_size;
      logic [15:0] free_id;
   } req_type_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] block_id;
      logic [15:0] block_addr;
      logic [15:0] block_size;
   } rsp_type;

endpackage

### hw/rtl/vpa_if.sv
// vpa_if: valid/ready channel carrying one payload beat
// depends on nothing but the payload type given by the instantiator
interface vpa_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/vpa_seq.sv
// vpa_seq: sequencer and shared compare/add unit of the allocator
// depends on vpa_pkg; walks free and used tables one entry per cycle
module vpa_seq #(
   parameter int unsigned FREE_SLOTS = 16,
   parameter int unsigned USED_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  vpa_pkg::req_type_type req,
   input  logic [1:0]           fit_mode,
   input  logic [15:0]          mem_total,
   input  logic [7:0]           slack_limit,
   input  logic                 seg_reload,
   output logic                 busy,
   output logic                 any_used,
   output logic                 done,
   output vpa_pkg::rsp_type     rsp
);
   import vpa_pkg::*;

   localparam int unsigned FW = $clog2(FREE_SLOTS);
   localparam int unsigned UW = $clog2(USED_SLOTS);
   localparam int unsigned FC = $clog2(FREE_SLOTS + 1);
   localparam int unsigned UC = $clog2(USED_SLOTS + 1);

   // table storage
   logic [15:0] fst_ff [FREE_SLOTS];
   logic [15:0] fln_ff [FREE_SLOTS];
   logic [FC-1:0] fcnt_ff;
   logic [15:0] uid_ff [USED_SLOTS];
   logic [15:0] ust_ff [USED_SLOTS];
   logic [15:0] uln_ff [USED_SLOTS];
   logic [USED_SLOTS-1:0] uval_ff;
   logic [15:0] next_id_ff;

   state_type state_ff, state_in;
   logic [FC-1:0] fi_ff;      // free scan pointer
   logic [UC-1:0] ui_ff;      // used scan pointer
   logic [FW-1:0] pick_ff;
   logic          found_ff;
   logic [15:0]   plen_ff;
   logic [15:0]   addr_ff, len_ff;
   rsp_type       rsp_ff;
   req_type_type  req_ff;
   logic [1:0]    mode_ff;

   assign busy     = (state_ff != S_IDLE);
   assign any_used = |uval_ff;
   assign rsp      = rsp_ff;
   assign done     = (state_ff == S_RESPOND);

   // current entries under the scan pointers
   logic [FW-1:0] fidx;
   logic [UW-1:0] uidx;
   logic [15:0]   cur_len, cur_st;
   logic          f_end, u_end;
   assign fidx    = fi_ff[FW-1:0];
   assign uidx    = ui_ff[UW-1:0];
   assign f_end   = (fi_ff >= fcnt_ff);
   assign u_end   = (ui_ff == UC'(USED_SLOTS));
   assign cur_len = fln_ff[fidx];
   assign cur_st  = fst_ff[fidx];

   // shared arithmetic unit
   logic [16:0] rem;
   logic        fits;
   assign fits = (cur_len >= req_ff.alloc_size);
   assign rem  = {1'b0, fln_ff[pick_ff]} - {1'b0, req_ff.alloc_size};

   logic left_adj, right_adj;
   logic [FW-1:0] pm1;
   assign pm1 = fidx - FW'(1);
   assign left_adj  = (fi_ff != '0) &&
                      ({1'b0, fst_ff[pm1]} + {1'b0, fln_ff[pm1]} == {1'b0, addr_ff});
   assign right_adj = !f_end && ({1'b0, addr_ff} + {1'b0, len_ff} == {1'b0, cur_st});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = start && req.req_type ? S_FREE_FIND :
                                  (req.alloc_size == '0 ? S_RESPOND : S_ALLOC_SCAN);
         end
         S_ALLOC_SCAN: begin
            if (f_end || (fits && mode_ff == FIT_FIRST))
               state_in = (found_ff || (!f_end && fits)) ? S_ALLOC_SLOT : S_RESPOND;
         end
         S_ALLOC_SLOT: begin
            if (u_end) state_in = S_RESPOND;
            else if (!uval_ff[uidx]) state_in = S_ALLOC_APPLY;
         end
         S_ALLOC_APPLY: state_in = (rem[15:0] <= {8'd0, slack_limit}) ?
                                   S_REMOVE_SHIFT : S_RESPOND;
         S_REMOVE_SHIFT: if (fi_ff + FC'(1) >= fcnt_ff) state_in = S_RESPOND;
         S_FREE_FIND: begin
            if (u_end) state_in = S_RESPOND;
            else if (uval_ff[uidx] && uid_ff[uidx] == req_ff.free_id) state_in = S_FREE_POS;
         end
         S_FREE_POS: if (f_end || cur_st >= addr_ff) state_in = S_FREE_APPLY;
         S_FREE_APPLY: begin
            if (left_adj && right_adj) state_in = S_REMOVE_SHIFT;
            else if (left_adj || right_adj) state_in = S_RESPOND;
            else if (fcnt_ff == FC'(FREE_SLOTS)) state_in = S_RESPOND;
            else state_in = S_INSERT_SHIFT;
         end
         S_INSERT_SHIFT: if (fi_ff == {1'b0, pick_ff}) state_in = S_RESPOND;
         S_RESPOND: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // datapath and tables
   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff    <= FC'(1);
         fst_ff[0]  <= '0;
         fln_ff[0]  <= MEM_TOTAL_RESET;
         uval_ff    <= '0;
         next_id_ff <= 16'd1;
      end else begin
         if (seg_reload) begin
            fcnt_ff   <= FC'(1);
            fst_ff[0] <= '0;
            fln_ff[0] <= mem_total;
         end
         case (state_ff)
            S_IDLE: begin
               req_ff   <= req;
               mode_ff  <= (fit_mode == 2'd3) ? FIT_FIRST : fit_mode;
               fi_ff    <= '0;
               ui_ff    <= '0;
               found_ff <= 1'b0;
               rsp_ff   <= '{status: (start && !req.req_type && req.alloc_size == '0)
                                     ? ST_BAD_SIZE : ST_OK, default: '0};
            end
            S_ALLOC_SCAN: begin
               if (!f_end && fits) begin
                  if (!found_ff || (mode_ff == FIT_BEST && cur_len <= plen_ff) ||
                      (mode_ff == FIT_WORST && cur_len >= plen_ff)) begin
                     pick_ff <= fidx;
                     plen_ff <= cur_len;
                  end
                  found_ff <= 1'b1;
               end
               fi_ff <= fi_ff + FC'(1);
               if (f_end && !found_ff) rsp_ff.status <= ST_NO_SPACE;
            end
            S_ALLOC_SLOT: begin
               if (u_end) rsp_ff.status <= ST_FULL;
               else if (uval_ff[uidx]) ui_ff <= ui_ff + UC'(1);
            end
            S_ALLOC_APPLY: begin
               uid_ff[uidx]  <= next_id_ff;
               ust_ff[uidx]  <= fst_ff[pick_ff];
               uval_ff[uidx] <= 1'b1;
               rsp_ff.block_id   <= next_id_ff;
               rsp_ff.block_addr <= fst_ff[pick_ff];
               next_id_ff <= (next_id_ff == ID_MAX) ? 16'd1 : next_id_ff + 16'd1;
               fi_ff <= {1'b0, pick_ff};
               if (rem[15:0] <= {8'd0, slack_limit}) begin
                  uln_ff[uidx] <= fln_ff[pick_ff];
                  rsp_ff.block_size <= fln_ff[pick_ff];
               end else begin
                  uln_ff[uidx] <= req_ff.alloc_size;
                  rsp_ff.block_size <= req_ff.alloc_size;
                  fst_ff[pick_ff] <= fst_ff[pick_ff] + req_ff.alloc_size;
                  fln_ff[pick_ff] <= rem[15:0];
               end
            end
            S_REMOVE_SHIFT: begin
               if (fi_ff + FC'(1) >= fcnt_ff) fcnt_ff <= fcnt_ff - FC'(1);
               else begin
                  fst_ff[fidx] <= fst_ff[fidx + FW'(1)];
                  fln_ff[fidx] <= fln_ff[fidx + FW'(1)];
               end
               fi_ff <= fi_ff + FC'(1);
            end
            S_FREE_FIND: begin
               if (u_end) rsp_ff.status <= ST_BAD_ID;
               else if (uval_ff[uidx] && uid_ff[uidx] == req_ff.free_id) begin
                  addr_ff <= ust_ff[uidx];
                  len_ff  <= uln_ff[uidx];
               end else ui_ff <= ui_ff + UC'(1);
            end
            S_FREE_POS: if (!(f_end || cur_st >= addr_ff)) fi_ff <= fi_ff + FC'(1);
            S_FREE_APPLY: begin
               // refused when the block touches nothing and the free table is full
               if (!left_adj && !right_adj && fcnt_ff == FC'(FREE_SLOTS)) begin
                  rsp_ff <= '{status: ST_FULL, default: '0};
               end else begin
                  rsp_ff.block_id   <= req_ff.free_id;
                  rsp_ff.block_addr <= addr_ff;
                  rsp_ff.block_size <= len_ff;
                  uval_ff[uidx]     <= 1'b0;
               end
               if (left_adj && right_adj) begin
                  fln_ff[pm1] <= fln_ff[pm1] + len_ff + cur_len;
               end else if (left_adj) begin
                  fln_ff[pm1] <= fln_ff[pm1] + len_ff;
               end else if (right_adj) begin
                  fst_ff[fidx] <= addr_ff;
                  fln_ff[fidx] <= cur_len + len_ff;
               end else if (fcnt_ff != FC'(FREE_SLOTS)) begin
                  pick_ff <= fidx;
                  fi_ff   <= fcnt_ff;
                  fcnt_ff <= fcnt_ff + FC'(1);
               end
            end
            S_INSERT_SHIFT: begin
               if (fi_ff == {1'b0, pick_ff}) begin
                  fst_ff[pick_ff] <= addr_ff;
                  fln_ff[pick_ff] <= len_ff;
               end else begin
                  fst_ff[fidx] <= fst_ff[fidx - FW'(1)];
                  fln_ff[fidx] <= fln_ff[fidx - FW'(1)];
                  fi_ff <= fi_ff - FC'(1);
               end
            end
            default: ;
         endcase
      end
   end

endmodule

### hw/rtl/variable_partition_allocator.sv
// variable_partition_allocator: top level with channels, csr and output register
// depends on vpa_pkg, vpa_if and vpa_seq
//
// Allocates and frees variable size blocks in [0, mem_total). One request beat is
// handled at a time: the sequencer walks the free table and used table one entry
// per cycle. The longest request is an allocate that scans every segment, searches
// every used slot and then closes up the free table; the response beat is then
// presented from the output register. req.ready is low from acceptance until the
// response beat has been taken.
module variable_partition_allocator #(
   parameter int unsigned FREE_SLOTS = 16,
   parameter int unsigned USED_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   vpa_if.sink         req,
   vpa_if.source       rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import vpa_pkg::*;

   logic [1:0]  fit_mode_ff;
   logic [7:0]  slack_ff;
   logic        busy, any_used, done, reload;
   rsp_type     seq_rsp;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        start;

   assign start     = req.valid && req.ready;
   assign req.ready = !busy && !rsp_valid_ff;
   // a nonzero range write with no block out rebuilds the free table directly from the write data
   assign reload    = csr_write_enable && csr_index == CSR_MEM_TOTAL &&
                      csr_write_data != '0 && !any_used;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= FIT_FIRST;
         slack_ff     <= SLACK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIT_MODE:  fit_mode_ff <= csr_write_data[1:0];
            CSR_MEM_TOTAL: ;
            CSR_SLACK:     slack_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   vpa_seq #(.FREE_SLOTS(FREE_SLOTS), .USED_SLOTS(USED_SLOTS)) u_seq (
      .clock, .reset, .start, .req(req.data),
      .fit_mode(fit_mode_ff), .mem_total(csr_write_data), .slack_limit(slack_ff),
      .seg_reload(reload), .busy, .any_used, .done, .rsp(seq_rsp)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) if (done) rsp_data_ff <= seq_rsp;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule

### hw/rtl/vpa_checker.sv
// vpa_checker: port level checks for the allocator
// depends on vpa_pkg; bound to variable_partition_allocator
module vpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vpa_pkg::rsp_type rsp_data
);
   import vpa_pkg::*;

   // no new request while a response beat waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response pending");
   // an accepted beat drops ready next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
   // failed responses carry no block
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.block_id == '0 &&
      rsp_data.block_size == '0)) else $error("error response with data");
   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response dropped");
endmodule

bind variable_partition_allocator vpa_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

### sim/vpa_tb_pkg.sv
// vpa_tb_pkg: request kinds and spare codes used by the allocator testbench
// depends on vpa_pkg for the csr index and fit mode widths
package vpa_tb_pkg;
   import vpa_pkg::*;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // index with no register behind it, and the undefined fit mode
   localparam csr_index_type CSR_SPARE = 2'd3;
   localparam logic [1:0]    FIT_SPARE = 2'd3;
endpackage

### sim/vpa_checker.sv
// vpa_tb_checker: shadow allocator that predicts every response beat and compares it
// depends on vpa_pkg and vpa_tb_pkg; watches the request, response and csr ports
module vpa_tb_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  vpa_pkg::req_type_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  vpa_pkg::rsp_type      rsp_data,
   input  logic                  csr_write_enable,
   input  vpa_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_write_data,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import vpa_pkg::*;
   import vpa_tb_pkg::*;

   localparam int SEGS  = 16;
   localparam int SLOTS = 16;

   logic [1:0]  fit_sel;
   logic [15:0] range_len;
   logic [7:0]  slack_max;
   logic [15:0] seg_base [SEGS];
   logic [15:0] seg_len  [SEGS];
   logic        seg_live [SEGS];
   logic [15:0] blk_id   [SLOTS];
   logic [15:0] blk_base [SLOTS];
   logic [15:0] blk_len  [SLOTS];
   logic        blk_live [SLOTS];
   int          id_counter;
   rsp_type     expected_rsps [$];

   assign outstanding = expected_rsps.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic int live_segs();
      int n;
      n = 0;
      while (n < SEGS && seg_live[n]) n++;
      return n;
   endfunction

   function automatic void whole_range();
      for (int i = 0; i < SEGS; i++) begin
         seg_base[i] = '0;
         seg_len[i]  = '0;
         seg_live[i] = 1'b0;
      end
      seg_len[0]  = range_len;
      seg_live[0] = 1'b1;
   endfunction

   function automatic void drop_seg(input int idx, input int n);
      for (int i = idx; i + 1 < n; i++) begin
         seg_base[i] = seg_base[i + 1];
         seg_len[i]  = seg_len[i + 1];
      end
      seg_base[n - 1] = '0;
      seg_len[n - 1]  = '0;
      seg_live[n - 1] = 1'b0;
   endfunction

   function automatic void shadow_reset();
      fit_sel   = FIT_FIRST;
      range_len = MEM_TOTAL_RESET;
      slack_max = SLACK_RESET;
      whole_range();
      for (int i = 0; i < SLOTS; i++) blk_live[i] = 1'b0;
      id_counter = 1;
   endfunction

   function automatic void shadow_csr(input csr_index_type idx, input logic [15:0] value);
      bit busy;
      busy = 1'b0;
      for (int i = 0; i < SLOTS; i++) busy |= blk_live[i];
      case (idx)
         CSR_FIT_MODE: fit_sel = value[1:0];
         CSR_MEM_TOTAL: begin
            // ignored while blocks are out or when zero
            if (value != 0 && !busy) begin
               range_len = value;
               whole_range();
            end
         end
         CSR_SLACK: slack_max = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic rsp_type allocate_block(input int size);
      rsp_type res;
      int      n, pick, slot, base, rem, granted;
      bit      found;
      logic [1:0] mode;
      res   = '0;
      pick  = 0;
      found = 1'b0;
      mode  = (fit_sel == FIT_SPARE) ? FIT_FIRST : fit_sel;
      if (size == 0) begin
         res.status = ST_BAD_SIZE;
         return res;
      end
      n = live_segs();
      // placement scan, ties go to the later segment
      for (int i = 0; i < n; i++) begin
         if (seg_len[i] < size) continue;
         if (!found) begin
            pick  = i;
            found = 1'b1;
            if (mode == FIT_FIRST) break;
         end else if (mode == FIT_BEST && seg_len[i] <= seg_len[pick]) begin
            pick = i;
         end else if (mode == FIT_WORST && seg_len[i] >= seg_len[pick]) begin
            pick = i;
         end
      end
      if (!found) begin
         res.status = ST_NO_SPACE;
         return res;
      end
      slot = SLOTS;
      for (int u = SLOTS - 1; u >= 0; u--) if (!blk_live[u]) slot = u;
      if (slot == SLOTS) begin
         res.status = ST_FULL;
         return res;
      end
      base    = seg_base[pick];
      rem     = int'(seg_len[pick]) - size;
      granted = size;
      if (rem <= slack_max) begin
         granted += rem;
         drop_seg(pick, n);
      end else begin
         seg_base[pick] = 16'(base + size);
         seg_len[pick]  = 16'(rem);
      end
      blk_id[slot]   = 16'(id_counter);
      blk_base[slot] = 16'(base);
      blk_len[slot]  = 16'(granted);
      blk_live[slot] = 1'b1;
      res.status     = ST_OK;
      res.block_id   = 16'(id_counter);
      res.block_addr = 16'(base);
      res.block_size = 16'(granted);
      id_counter     = (id_counter >= 65535) ? 1 : id_counter + 1;
      return res;
   endfunction

   function automatic rsp_type release_block(input logic [15:0] fid);
      rsp_type res;
      int      slot, n, p, base, len;
      bit      left, right;
      res  = '0;
      slot = SLOTS;
      for (int u = SLOTS - 1; u >= 0; u--) if (blk_live[u] && blk_id[u] == fid) slot = u;
      if (slot == SLOTS) begin
         res.status = ST_BAD_ID;
         return res;
      end
      base = blk_base[slot];
      len  = blk_len[slot];
      n    = live_segs();
      p    = 0;
      while (p < n && seg_base[p] < base) p++;
      left  = p > 0 && int'(seg_base[p - 1]) + int'(seg_len[p - 1]) == base;
      right = p < n && base + len == int'(seg_base[p]);
      // merge with exact neighbors only, else insert sorted
      if (left && right) begin
         seg_len[p - 1] = 16'(seg_len[p - 1] + len + seg_len[p]);
         drop_seg(p, n);
      end else if (left) begin
         seg_len[p - 1] = 16'(seg_len[p - 1] + len);
      end else if (right) begin
         seg_base[p] = 16'(base);
         seg_len[p]  = 16'(seg_len[p] + len);
      end else begin
         if (n >= SEGS) begin
            res.status = ST_FULL;
            return res;
         end
         for (int i = n; i > p; i--) begin
            seg_base[i] = seg_base[i - 1];
            seg_len[i]  = seg_len[i - 1];
         end
         seg_base[p] = 16'(base);
         seg_len[p]  = 16'(len);
         seg_live[n] = 1'b1;
      end
      blk_live[slot] = 1'b0;
      res.status     = ST_OK;
      res.block_id   = fid;
      res.block_addr = 16'(base);
      res.block_size = 16'(len);
      return res;
   endfunction

   // watch csr writes, request beats and response beats
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_reset();
         expected_rsps.delete();
      end else begin
         if (csr_write_enable) shadow_csr(csr_index, csr_write_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response beat", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.block_id !== want.block_id)
                  report_mismatch("block_id", rsp_data.block_id, want.block_id);
               if (rsp_data.block_addr !== want.block_addr)
                  report_mismatch("block_addr", rsp_data.block_addr, want.block_addr);
               if (rsp_data.block_size !== want.block_size)
                  report_mismatch("block_size", rsp_data.block_size, want.block_size);
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.req_type == REQ_ALLOC)
               expected_rsps.push_back(allocate_block(int'(req_data.alloc_size)));
            else
               expected_rsps.push_back(release_block(req_data.free_id));
         end
      end
   end

   initial mismatches = 0;
endmodule

### sim/tb.sv
// tb: stimulus and verdict for the variable partition allocator
// depends on vpa_pkg, vpa_tb_pkg, vpa_if, vpa_tb_checker and the allocator rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vpa_pkg::*;
   import vpa_tb_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [15:0]   csr_write_data;
   int            mismatches;
   int            outstanding;
   int            cycles = 0;
   bit            no_idle = 1'b0;
   logic          sent_kinds [$];
   logic [15:0]   live_ids [$];

   vpa_if #(.payload_type(req_type_type)) req_ch ();
   vpa_if #(.payload_type(rsp_type))      rsp_ch ();

   variable_partition_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   vpa_tb_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_data         (req_ch.data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_data         (rsp_ch.data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(99) >= 25);
      end
   end

   // track ids handed out so frees mostly hit live blocks
   always @(posedge clock) begin
      int k;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready && sent_kinds.size() > 0) begin
            k = sent_kinds.pop_front();
            if (rsp_ch.data.status == ST_OK) begin
               if (k == REQ_ALLOC) begin
                  live_ids.push_back(rsp_ch.data.block_id);
               end else begin
                  for (int i = 0; i < live_ids.size(); i++)
                     if (live_ids[i] == rsp_ch.data.block_id) begin
                        live_ids.delete(i);
                        break;
                     end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) sent_kinds.push_back(req_ch.data.req_type);
      end
   end

   task automatic send_beat(input logic kind, input logic [15:0] size, input logic [15:0] fid);
      if (!no_idle && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.data.req_type   <= kind;
      req_ch.data.alloc_size <= size;
      req_ch.data.free_id    <= fid;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // return every live block, one beat at a time
   task automatic free_all();
      logic [15:0] fid;
      while (live_ids.size() > 0) begin
         fid = live_ids[0];
         send_beat(REQ_FREE, $urandom, fid);
         wait_idle();
         // a free refused for a full free table stays live, retry it later
         if (live_ids.size() > 0 && live_ids[0] == fid)
            live_ids.push_back(live_ids.pop_front());
      end
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [15:0] total,
                             input logic [7:0] slack);
      wait_idle();
      free_all();
      csr_write(CSR_MEM_TOTAL, 16'd0);
      csr_write(CSR_SPARE, 16'hFFFF);
      csr_write(CSR_FIT_MODE, {14'h3FFF, mode});
      csr_write(CSR_MEM_TOTAL, total);
      csr_write(CSR_SLACK, {8'hFF, slack});
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_traffic(input int count, input int max_size);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (live_ids.size() > 0 && roll < 40) begin
            if ($urandom_range(9) == 0)
               send_beat(REQ_FREE, $urandom, $urandom);
            else
               send_beat(REQ_FREE, $urandom, live_ids[$urandom_range(live_ids.size() - 1)]);
         end else if (roll < 45) begin
            send_beat(REQ_ALLOC, 16'd0, $urandom);
         end else if (roll < 50) begin
            send_beat(REQ_ALLOC, $urandom, $urandom);
         end else begin
            send_beat(REQ_ALLOC, $urandom_range(1, max_size), $urandom);
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_FIT_MODE;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero size, no space, carve, unknown id, merges, slack absorb
      send_beat(REQ_ALLOC, 16'd0, 16'd0);
      send_beat(REQ_ALLOC, 16'hFFFF, 16'hFFFF);
      send_beat(REQ_ALLOC, 16'd100, 16'd0);
      send_beat(REQ_ALLOC, 16'd200, 16'd0);
      send_beat(REQ_ALLOC, 16'd300, 16'd0);
      wait_idle();
      // range write while blocks are out is dropped
      csr_write(CSR_MEM_TOTAL, 16'd2000);
      csr_write_enable <= 1'b0;
      send_beat(REQ_FREE, 16'd0, 16'd0);
      send_beat(REQ_FREE, 16'hFFFF, 16'hFFFF);
      send_beat(REQ_FREE, 16'd0, 16'd2);
      send_beat(REQ_FREE, 16'd0, 16'd1);
      send_beat(REQ_FREE, 16'd0, 16'd3);
      send_beat(REQ_ALLOC, 16'd1019, 16'd0);
      send_beat(REQ_FREE, 16'd0, 16'd4);
      send_beat(REQ_FREE, 16'd0, 16'd4);
      // fill the used table, the last one is refused
      for (int i = 0; i < 17; i++) send_beat(REQ_ALLOC, 16'd10, 16'd0);
      wait_idle();

      // best fit over the full range, back to back
      set_config(FIT_BEST, 16'hFFFF, 8'd255);
      no_idle = 1'b1;
      random_traffic(350, 9000);
      no_idle = 1'b0;

      set_config(FIT_FIRST, 16'd1024, 8'd10);
      random_traffic(350, 120);

      set_config(FIT_WORST, 16'd500, 8'd0);
      random_traffic(350, 60);

      set_config(FIT_SPARE, 16'd1, 8'd0);
      random_traffic(150, 2);

      set_config(FIT_BEST, 16'd200, 8'd3);
      random_traffic(350, 30);

      wait_idle();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
